### rtl/h264ns_pkg.sv
`default_nettype none

package h264ns_pkg;

  localparam int LENGTH_BITS_DEF = 24;
  localparam int QUEUE_DEPTH     = 4;
  localparam int PREFIX_BITS     = 3;

  localparam logic [7:0] HDR_FZ_MASK   = 8'h80;
  localparam logic [7:0] HDR_REF_MASK  = 8'h60;
  localparam logic [7:0] HDR_TYPE_MASK = 8'h1f;

  localparam logic [4:0] TARGET_RESET = 5'd5;

  typedef enum logic [1:0] {
    STATUS_COMPLETE     = 2'd0,
    STATUS_NO_START     = 2'd1,
    STATUS_UNTERMINATED = 2'd2
  } status_t;

  // Everything of one result except its length, whose width is a parameter.
  typedef struct packed {
    status_t                status;
    logic [PREFIX_BITS-1:0] prefix;
    logic                   fz;
    logic [1:0]             ref_idc;
    logic [4:0]             unit_type;
    logic                   match;
    logic                   last;
  } res_info_t;

  // Results produced by one accepted word, packed from the front.
  typedef struct packed {
    logic [1:0] count;
    res_info_t  r0;
    res_info_t  r1;
  } push_ctl_t;

  function automatic res_info_t make_info(status_t st, logic [PREFIX_BITS-1:0] pre,
                                          logic [7:0] hdr, logic hdr_ok,
                                          logic [4:0] target, logic last);
    logic [7:0] h;
    res_info_t  r;
    h           = hdr_ok ? hdr : 8'h00;
    r.status    = st;
    r.prefix    = pre;
    r.fz        = |(h & HDR_FZ_MASK);
    r.ref_idc   = h[6:5] & HDR_REF_MASK[6:5];
    r.unit_type = h[4:0] & HDR_TYPE_MASK[4:0];
    r.match     = hdr_ok && ((h[4:0] & HDR_TYPE_MASK[4:0]) == target);
    r.last      = last;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/h264_nal_unit_splitter_top.sv
// Channel  Direction  Handshake               Word
// in       input      in_valid / in_ready     data_byte, end_of_buffer
// out      output     out_valid / out_ready   status .. last_of_run, one result per word
// cfg      input      cfg_wr_en               cfg_wr_data (target_nal_type)
//
// Each input byte is scanned in the cycle it is accepted and
// its results are written straight into a four-entry result queue.
// A byte yields at most two results; the output side drains one result per cycle,
// so bytes flow at one per cycle whenever results are taken as fast as they come.
// in_ready depends only on queue occupancy (two free entries needed), never on out_ready.
// Reset is synchronous and clears the scanner and the queue; target_nal_type resets to 5.
`default_nettype none

module h264_nal_unit_splitter_top
  import h264ns_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   end_of_buffer,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [1:0]             status,
  output logic      [LENGTH_BITS-1:0] nal_length,
  output logic      [2:0]             prefix_length,
  output logic                        forbidden_zero,
  output logic      [1:0]             ref_idc,
  output logic      [4:0]             unit_type,
  output logic                        type_match,
  output logic                        last_of_run,
  input  wire logic                   cfg_wr_en,
  input  wire logic [4:0]             cfg_wr_data
);

  logic [4:0]             target;
  logic                   accept;
  push_ctl_t              push;
  logic [LENGTH_BITS-1:0] len0, len1;
  res_info_t              head_info;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= TARGET_RESET;
    end else if (cfg_wr_en) begin
      target <= cfg_wr_data;
    end
  end

  h264ns_parse #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .end_of_buffer(end_of_buffer),
    .target       (target),
    .push         (push),
    .len0         (len0),
    .len1         (len1)
  );

  h264ns_outq #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .len0     (len0),
    .len1     (len1),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head_info(head_info),
    .head_len (nal_length)
  );

  assign status         = head_info.status;
  assign prefix_length  = head_info.prefix;
  assign forbidden_zero = head_info.fz;
  assign ref_idc        = head_info.ref_idc;
  assign unit_type      = head_info.unit_type;
  assign type_match     = head_info.match;
  assign last_of_run    = head_info.last;

endmodule

`default_nettype wire

### rtl/h264ns_parse.sv
`default_nettype none

module h264ns_parse
  import h264ns_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire logic [7:0]             data_byte,
  input  wire logic                   end_of_buffer,
  input  wire logic [4:0]             target,
  output push_ctl_t                   push,
  output logic      [LENGTH_BITS-1:0] len0,
  output logic      [LENGTH_BITS-1:0] len1
);

  localparam logic [LENGTH_BITS-1:0] LenMax = '1;

  logic [1:0]             zero_run, zero_run_next;
  logic                   unit_open, unit_open_next;
  logic                   header_pending, header_pending_next;
  logic [LENGTH_BITS-1:0] unit_count, unit_count_next;
  logic [PREFIX_BITS-1:0] open_prefix, open_prefix_next;
  logic [7:0]             header_byte, header_byte_next;

  logic                   is_start;
  logic [PREFIX_BITS-1:0] new_prefix;
  logic [LENGTH_BITS-1:0] new_prefix_w;
  logic [LENGTH_BITS-1:0] count_inc;
  logic [LENGTH_BITS-1:0] closed_len;
  logic                   have_closed;
  res_info_t              closed_info;
  res_info_t              end_info;
  logic [LENGTH_BITS-1:0] end_len;

  always_comb begin
    count_inc = unit_count;
    if (unit_open && unit_count != LenMax) begin
      count_inc = unit_count + LENGTH_BITS'(1);
    end

    is_start     = (data_byte == 8'h01) && (zero_run >= 2'd2);
    new_prefix   = (zero_run == 2'd3) ? 3'd4 : 3'd3;
    new_prefix_w = {{(LENGTH_BITS-PREFIX_BITS){1'b0}}, new_prefix};

    // The closed unit's length runs from its own prefix up to the new prefix.
    if (count_inc == LenMax) begin
      closed_len = LenMax;
    end else if (count_inc >= new_prefix_w) begin
      closed_len = count_inc - new_prefix_w;
    end else begin
      closed_len = '0;
    end
    have_closed = is_start && unit_open;
    closed_info = make_info(STATUS_COMPLETE, open_prefix, header_byte, !header_pending,
                            target, !end_of_buffer);

    zero_run_next       = zero_run;
    unit_open_next      = unit_open;
    header_pending_next = header_pending;
    unit_count_next     = count_inc;
    open_prefix_next    = open_prefix;
    header_byte_next    = header_byte;

    if (is_start) begin
      unit_open_next      = 1'b1;
      unit_count_next     = new_prefix_w;
      open_prefix_next    = new_prefix;
      header_pending_next = 1'b1;
      header_byte_next    = 8'h00;
      zero_run_next       = 2'd0;
    end else begin
      if (header_pending) begin
        header_byte_next    = data_byte;
        header_pending_next = 1'b0;
      end
      if (data_byte == 8'h00) begin
        zero_run_next = (zero_run == 2'd3) ? 2'd3 : zero_run + 2'd1;
      end else begin
        zero_run_next = 2'd0;
      end
    end

    // The end-of-buffer report sees the state as this word leaves it.
    if (unit_open_next) begin
      end_info = make_info(STATUS_UNTERMINATED, open_prefix_next, header_byte_next,
                           !header_pending_next, target, 1'b1);
      end_len  = unit_count_next;
    end else begin
      end_info = make_info(STATUS_NO_START, '0, 8'h00, 1'b0, target, 1'b1);
      end_len  = '0;
    end

    push.count = 2'd0;
    push.r0    = closed_info;
    push.r1    = end_info;
    len0       = closed_len;
    len1       = end_len;
    if (accept) begin
      if (have_closed) begin
        push.count = end_of_buffer ? 2'd2 : 2'd1;
      end else if (end_of_buffer) begin
        push.count = 2'd1;
        push.r0    = end_info;
        len0       = end_len;
      end
    end

    if (accept && end_of_buffer) begin
      zero_run_next       = 2'd0;
      unit_open_next      = 1'b0;
      header_pending_next = 1'b0;
      unit_count_next     = '0;
      open_prefix_next    = '0;
      header_byte_next    = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_run       <= 2'd0;
      unit_open      <= 1'b0;
      header_pending <= 1'b0;
      unit_count     <= '0;
      open_prefix    <= '0;
      header_byte    <= 8'h00;
    end else if (accept) begin
      zero_run       <= zero_run_next;
      unit_open      <= unit_open_next;
      header_pending <= header_pending_next;
      unit_count     <= unit_count_next;
      open_prefix    <= open_prefix_next;
      header_byte    <= header_byte_next;
    end
  end

  // A pair of results always ends on the second one.
  assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> !push.r0.last && push.r1.last)
    else $error("first of two results marked last");

  // The end of a buffer always returns the scanner to its idle state.
  assert property (@(posedge clk) disable iff (rst)
    accept && end_of_buffer |=> !unit_open && zero_run == 2'd0 && !header_pending)
    else $error("state not cleared after end of buffer");

  // An open unit always carries a 3- or 4-byte prefix.
  assert property (@(posedge clk) disable iff (rst)
    unit_open |-> open_prefix == 3'd3 || open_prefix == 3'd4)
    else $error("open unit with bad prefix length");

endmodule

`default_nettype wire

### rtl/h264ns_outq.sv
`default_nettype none

module h264ns_outq
  import h264ns_pkg::*;
#(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire push_ctl_t              push,
  input  wire logic [LENGTH_BITS-1:0] len0,
  input  wire logic [LENGTH_BITS-1:0] len1,
  output logic                        room,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output res_info_t                   head_info,
  output logic      [LENGTH_BITS-1:0] head_len
);

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Depth = CntW'(QUEUE_DEPTH);

  res_info_t              info_q [QUEUE_DEPTH];
  logic [LENGTH_BITS-1:0] len_q  [QUEUE_DEPTH];
  logic [PtrW-1:0]        rd_ptr, wr_ptr;
  logic [CntW-1:0]        count, count_next;
  logic                   pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != '0);
  // Two free entries are kept so that any word can be taken in one go.
  assign room       = (count <= Depth - CntW'(2));
  assign head_info  = info_q[rd_ptr];
  assign head_len   = len_q[rd_ptr];
  assign count_next = count + CntW'(push.count) - CntW'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      info_q[wr_ptr] <= push.r0;
      len_q[wr_ptr]  <= len0;
    end
    if (push.count == 2'd2) begin
      info_q[wr_ptr + PtrW'(1)] <= push.r1;
      len_q[wr_ptr + PtrW'(1)]  <= len1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + PtrW'(pop);
      wr_ptr <= wr_ptr + PtrW'(push.count);
      count  <= count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= Depth)
    else $error("result queue overflow");

  assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> CntW'(push.count) <= Depth - count)
    else $error("push into a queue without room");

  assert property (@(posedge clk) disable iff (rst)
    wr_ptr == rd_ptr + PtrW'(count))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire
